### design/shm_pkg.sv
package shm_pkg;

  // Operator bank size and the widths that follow from it
  localparam int NUM_OPS   = 8192;
  localparam int ADDR_W    = $clog2(NUM_OPS);
  localparam int OP_W      = $clog2(NUM_OPS) + 1;
  localparam int SAMPLE_W  = 16;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int SUM_W     = ((OP_W > DIFF_W) ? OP_W : DIFF_W) + 1;
  localparam int W_W       = 15;
  localparam int PROD_W    = W_W + 1 + OP_W;
  localparam int ACC_W     = PROD_W + ADDR_W;
  localparam int OUT_W     = 41;
  localparam int BIG_W     = (ACC_W > OUT_W) ? ACC_W : OUT_W;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_OPS - 1);

  // Weight generation constants (Q60 series arithmetic)
  localparam logic [63:0] Q_ONE       = 64'd1 << 60;
  localparam logic [63:0] WEIGHT_DEN  = 64'd3200000000;
  localparam longint      PEAK_INDEX  = 64'sd2000;
  localparam int          NUM_TERMS   = 30;
  localparam int          NUM_SQUARES = 5;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_WALK,
    SEQ_DRAIN
  } seq_state_t;

  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic                     last;
    logic [W_W-1:0]           weight;
    logic signed [OP_W-1:0]   op;
  } mac_req_t;

  // (a*b) >> 60, truncated to 64 bits
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // floor(num * 2^60 / den), num below den
  function automatic logic [63:0] qdiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = num;
    for (int k = 0; k < 60; k++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem  = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Series term divided by its index
  function automatic logic [63:0] div_term(input logic [63:0] t, input logic [4:0] k);
    case (k)
      5'd1:    return t / 64'd1;
      5'd2:    return t / 64'd2;
      5'd3:    return t / 64'd3;
      5'd4:    return t / 64'd4;
      5'd5:    return t / 64'd5;
      5'd6:    return t / 64'd6;
      5'd7:    return t / 64'd7;
      5'd8:    return t / 64'd8;
      5'd9:    return t / 64'd9;
      5'd10:   return t / 64'd10;
      5'd11:   return t / 64'd11;
      5'd12:   return t / 64'd12;
      5'd13:   return t / 64'd13;
      5'd14:   return t / 64'd14;
      5'd15:   return t / 64'd15;
      5'd16:   return t / 64'd16;
      5'd17:   return t / 64'd17;
      5'd18:   return t / 64'd18;
      5'd19:   return t / 64'd19;
      5'd20:   return t / 64'd20;
      5'd21:   return t / 64'd21;
      5'd22:   return t / 64'd22;
      5'd23:   return t / 64'd23;
      5'd24:   return t / 64'd24;
      5'd25:   return t / 64'd25;
      5'd26:   return t / 64'd26;
      5'd27:   return t / 64'd27;
      5'd28:   return t / 64'd28;
      5'd29:   return t / 64'd29;
      5'd30:   return t / 64'd30;
      default: return t;
    endcase
  endfunction

  // round(2^24 * 0.001 * exp(-0.07*(0.001*idx - 2)^2)), evaluated at elaboration
  function automatic logic [W_W-1:0] make_weight(input int idx);
    longint      d;
    logic [63:0] num;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    logic [63:0] v;
    d   = longint'(idx) - PEAK_INDEX;
    num = 64'(longint'(7) * d * d);
    if (num >= WEIGHT_DEN) begin
      return '0;
    end
    x   = qdiv(num, WEIGHT_DEN);
    t   = Q_ONE;
    pos = Q_ONE;
    neg = '0;
    for (int k = 1; k <= NUM_TERMS; k++) begin
      t = div_term(qmul(t, x), 5'(k));
      if (k[0]) begin
        neg = neg + t;
      end else begin
        pos = pos + t;
      end
    end
    r = (pos > neg) ? (pos - neg) : '0;
    for (int k = 0; k < NUM_SQUARES; k++) begin
      r = qmul(r, r);
    end
    v = ((r >> 22) << 24) / 64'd1000;
    return W_W'((v + (64'd1 << 37)) >> 38);
  endfunction

endpackage

### design/shm_sample_if.sv
interface shm_sample_if import shm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### design/shm_result_if.sv
interface shm_result_if import shm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] hysteresis_out;

  modport source (output valid, output hysteresis_out, input ready);
  modport sink   (input valid, input hysteresis_out, output ready);
endinterface

### design/shm_op_ram.sv
module shm_op_ram import shm_pkg::*; (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic signed [OP_W-1:0]   rd_data,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [OP_W-1:0]   wr_data
);

  logic [OP_W-1:0] mem [NUM_OPS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= $signed(mem[rd_addr]);
    end
  end

endmodule

### design/shm_weight_rom.sv
module shm_weight_rom import shm_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [W_W-1:0]    weight
);

  logic [W_W-1:0] rom_word [NUM_OPS];

  for (genvar gi = 0; gi < NUM_OPS; gi++) begin : g_word
    localparam logic [W_W-1:0] WORD = make_weight(gi);
    assign rom_word[gi] = WORD;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      weight <= rom_word[rd_addr];
    end
  end

endmodule

### design/shm_seq.sv
module shm_seq import shm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] start_sample,
  output logic                       idle,
  output logic                       rd_en,
  output logic [ADDR_W-1:0]          rd_addr,
  input  logic signed [OP_W-1:0]     rd_data,
  input  logic [W_W-1:0]             weight,
  output logic                       wr_en,
  output logic [ADDR_W-1:0]          wr_addr,
  output logic signed [OP_W-1:0]     wr_data,
  output mac_req_t                   mac_req,
  input  logic                       res_taken
);

  seq_state_t                 state;
  seq_state_t                 state_next;
  logic [ADDR_W-1:0]          addr;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [SAMPLE_W-1:0] prev;
  logic                       fresh;
  logic                       s1_valid;
  logic                       s1_first;
  logic                       s1_last;
  logic [ADDR_W-1:0]          s1_addr;

  logic signed [OP_W-1:0]     cur;
  logic signed [SUM_W-1:0]    total;
  logic signed [SUM_W-1:0]    thr;
  logic signed [SUM_W-1:0]    clamped;

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE:  if (start) state_next = SEQ_WALK;
      SEQ_WALK:  if (addr == LAST_ADDR) state_next = SEQ_DRAIN;
      SEQ_DRAIN: if (res_taken) state_next = SEQ_IDLE;
      default:   state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    idle  = 1'b0;
    rd_en = 1'b0;
    case (state)
      SEQ_IDLE:  idle  = 1'b1;
      SEQ_WALK:  rd_en = 1'b1;
      SEQ_DRAIN: ;
      default:   ;
    endcase
  end

  assign rd_addr = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SEQ_IDLE;
      prev     <= '0;
      fresh    <= 1'b1;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= rd_en;
      if (start) begin
        prev <= start_sample;
      end
      // entries never written since reset read as zero until the first walk ends
      if (s1_valid && s1_last) begin
        fresh <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      diff <= DIFF_W'(start_sample) - DIFF_W'(prev);
      addr <= '0;
    end else if (rd_en) begin
      addr <= addr + 1'b1;
    end
    s1_addr  <= addr;
    s1_first <= (addr == '0);
    s1_last  <= (addr == LAST_ADDR);
  end

  // read data arrives: add the step, clamp to the operator's threshold, write back
  always_comb begin
    cur   = fresh ? '0 : rd_data;
    total = SUM_W'(cur) + SUM_W'(diff);
    thr   = $signed(SUM_W'(s1_addr));
    if (total > thr) begin
      clamped = thr;
    end else if (total < -thr) begin
      clamped = -thr;
    end else begin
      clamped = total;
    end
  end

  assign wr_en   = s1_valid;
  assign wr_addr = s1_addr;
  assign wr_data = OP_W'(clamped);

  always_comb begin
    mac_req.valid  = s1_valid;
    mac_req.first  = s1_first;
    mac_req.last   = s1_last;
    mac_req.weight = weight;
    mac_req.op     = OP_W'(clamped);
  end

endmodule

### design/shm_mac.sv
module shm_mac import shm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_req_t                req,
  output logic                    res_valid,
  output logic signed [OUT_W-1:0] res_value,
  input  logic                    res_take
);

  localparam logic signed [BIG_W-1:0] OUT_HI =
    {{(BIG_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [BIG_W-1:0] OUT_LO =
    {{(BIG_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

  logic                     a_valid;
  logic                     a_first;
  logic                     a_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     b_done;
  logic signed [BIG_W-1:0]  acc_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_done    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      a_valid <= req.valid;
      b_done  <= a_valid && a_last;
      if (b_done) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_first <= req.first;
    a_last  <= req.last;
    prod    <= $signed({1'b0, req.weight}) * $signed(req.op);
    if (a_valid) begin
      acc <= (a_first ? '0 : acc) + ACC_W'(prod);
    end
  end

  assign acc_ext = BIG_W'(acc);

  always_ff @(posedge clk) begin
    if (b_done) begin
      if (acc_ext > OUT_HI) begin
        res_value <= OUT_W'(OUT_HI);
      end else if (acc_ext < OUT_LO) begin
        res_value <= OUT_W'(OUT_LO);
      end else begin
        res_value <= OUT_W'(acc_ext);
      end
    end
  end

endmodule

### design/stop_operator_hysteresis_model_core.sv
// Stop-operator hysteresis model core.
// samples (sink): one request carries a signed 16-bit sample in units of 0.001.
// results (source): one request per sample, hysteresis_out, the signed 41-bit
// weighted sum of the updated stop operators in units of 2^-24 input unit,
// saturated to the field range.
//
// Each sample walks the whole operator memory once, one entry a cycle: read,
// add the sample step, clamp to the entry's threshold, write back, weight and
// accumulate. The sum passes the MAC product, accumulator and result registers
// and then the output register; the next sample is accepted only once the
// result has moved out of the MAC result register into the output register.
//
// Reset clears the previous sample and the control state and holds the sample
// side closed. The operator memory is not swept: until the first walk after
// reset has finished, every read is taken as zero, so reset needs no clearing pass.
//
// A stalled receiver holds the result in the output register; the next sample
// is still accepted and walked, and its result waits in the MAC result register
// until the output register frees.
module stop_operator_hysteresis_model_core import shm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  shm_sample_if.sink   samples,
  shm_result_if.source results
);

  logic                    start;
  logic                    idle;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic signed [OP_W-1:0]  rd_data;
  logic [W_W-1:0]          weight;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [OP_W-1:0]  wr_data;
  mac_req_t                mac_req;
  logic                    res_valid;
  logic signed [OUT_W-1:0] res_value;
  logic                    res_take;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_data;

  // take a new sample only between walks, never while in reset
  assign samples.ready = idle && !rst;
  assign start         = samples.valid && samples.ready;

  shm_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .start_sample (samples.sample),
    .idle         (idle),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .weight       (weight),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .mac_req      (mac_req),
    .res_taken    (res_take)
  );

  shm_op_ram u_op_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  shm_weight_rom u_weight_rom (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .weight  (weight)
  );

  shm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .req       (mac_req),
    .res_valid (res_valid),
    .res_value (res_value),
    .res_take  (res_take)
  );

  // move the finished sum into the output register once it is free or draining
  assign res_take = res_valid && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res_value;
    end
  end

  assign results.valid          = out_valid;
  assign results.hysteresis_out = out_data;

endmodule

### design/shm_checker.sv
module shm_checker import shm_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_data
);

  // a stalled result request holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an accepted sample closes the sample side as its walk starts
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("sample accepted during a walk");

  // a new result only appears as a walk finishes
  a_result_after_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result offered while idle");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind stop_operator_hysteresis_model_core shm_checker u_shm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.hysteresis_out)
);

### tb/tb_top.sv
// Stop-operator hysteresis core testbench.
module tb_top;
  import shm_pkg::*;

  localparam int     HALF_PERIOD     = 6;
  localparam int     MAX_WAIT        = 17;
  localparam int     DRAIN_LIMIT     = 100_000;
  localparam longint WATCHDOG_CYCLES = 6_000_000;
  localparam longint OUT_HI          = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_LO          = -(longint'(1) << (OUT_W - 1));
  localparam int     RANDOM_ITEMS    = 100;

  logic clk;
  logic rst;

  shm_sample_if samples ();
  shm_result_if results ();

  stop_operator_hysteresis_model_core dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results)
  );

  // Scoreboard state: the predicted operator bank, its weights and the
  // queue of hysteresis outputs still owed by the block.
  longint                  op_weight [NUM_OPS];
  int                      op_state  [NUM_OPS];
  int                      last_sample;
  logic signed [OUT_W-1:0] pending_outputs [$];
  int                      fail_count;

  // Pacing controls. tx_idle/rx_idle switch the random gaps on and off so
  // that some stretches run at full rate; hold_left is a long receiver
  // hold-off, counted down by the result pacing process.
  bit tx_idle;
  bit rx_idle;
  int hold_left;
  int out_stall_left;

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // ---------------------------------------------------------------------
  // Weight table
  // ---------------------------------------------------------------------

  // Fixed-point Q60 product, truncated.
  function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b};
    return wide[123:60];
  endfunction

  // Gaussian weight round(2^24 * 0.001 * exp(-0.07*(0.001*idx - 2)^2)).
  // exp(-a) is built as exp(-a/32) to the 32nd power; the short exponent
  // comes from an alternating series, every term truncated.
  function automatic longint gauss_weight(input int idx);
    longint      offset;
    logic [63:0] num;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] plus;
    logic [63:0] minus;
    logic [63:0] r;
    logic [63:0] scaled;
    logic [127:0] wide;
    offset = longint'(idx) - PEAK_INDEX;
    num    = 64'(longint'(7) * offset * offset);
    if (num >= WEIGHT_DEN) begin
      return 0;
    end
    // floor(num * 2^60 / den) straight from a wide division
    wide  = {64'd0, num} << 60;
    x     = 64'(wide / {64'd0, WEIGHT_DEN});
    term  = Q_ONE;
    plus  = Q_ONE;
    minus = '0;
    for (int k = 1; k <= NUM_TERMS; k++) begin
      term = q60_product(term, x) / 64'(k);
      if (k % 2 == 1) begin
        minus = minus + term;
      end else begin
        plus = plus + term;
      end
    end
    r = (plus > minus) ? (plus - minus) : '0;
    for (int k = 0; k < NUM_SQUARES; k++) begin
      r = q60_product(r, r);
    end
    scaled = ((r >> 22) << 24) / 64'd1000;
    return longint'((scaled + (64'd1 << 37)) >> 38);
  endfunction

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Move every stop operator by the sample step, clamp each to its own
  // threshold and return the saturated weighted sum. Operator zero has a
  // threshold of zero and so never leaves zero.
  function automatic logic signed [OUT_W-1:0] walk_operator_bank(
    input logic signed [SAMPLE_W-1:0] value
  );
    int     step;
    int     v;
    longint acc;
    step = int'(value) - last_sample;
    acc  = 0;
    for (int i = 0; i < NUM_OPS; i++) begin
      v = op_state[i] + step;
      if (v > i) begin
        v = i;
      end
      if (v < -i) begin
        v = -i;
      end
      op_state[i] = v;
      acc += op_weight[i] * longint'(v);
    end
    last_sample = int'(value);
    // Saturate a sum outside the output field to the nearest bound. With
    // this bank size the weighted sum stays well inside it.
    if (acc > OUT_HI) begin
      acc = OUT_HI;
    end
    if (acc < OUT_LO) begin
      acc = OUT_LO;
    end
    return OUT_W'(acc);
  endfunction

  // ---------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------

  // Offer one sample request and hold it until the block takes it. Returns
  // at the accepting rising edge with valid still high, so that a
  // back-to-back request keeps valid up without a dip; any pause in the
  // stream must go through release_samples.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] value);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
    @(negedge clk);
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples.valid  <= 1'b1;
    samples.sample <= value;
    do @(posedge clk); while (!samples.ready);
    pending_outputs.push_back(walk_operator_bank(value));
  endtask

  // Drop valid before the next edge once the stream pauses.
  task automatic release_samples();
    @(negedge clk);
    samples.valid <= 1'b0;
  endtask

  // Wait until every owed result has come back, within a limit.
  task automatic await_drain();
    int waited;
    waited = 0;
    while (pending_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Drive ready at the falling edge: a long hold-off when one is asked
  // for, otherwise the per-result stall drawn when the last request left.
  initial begin : result_pacing
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        results.ready <= 1'b0;
        hold_left--;
      end else if (out_stall_left > 0) begin
        results.ready <= 1'b0;
        out_stall_left--;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result request with the oldest prediction.
  initial begin : result_check
    logic signed [OUT_W-1:0] want;
    forever begin
      @(posedge clk);
      if (!rst && results.valid && results.ready) begin
        if (pending_outputs.size() == 0) begin
          $error("hysteresis_out: no result expected, got %0d", results.hysteresis_out);
          fail_count++;
        end else begin
          want = pending_outputs.pop_front();
          if (results.hysteresis_out !== want) begin
            $error("hysteresis_out: expected %0d, got %0d", want, results.hysteresis_out);
            fail_count++;
          end
        end
        out_stall_left = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes, full-scale swings that drive every operator into its
  // clamp both ways, a single-unit step and alternating bit patterns.
  task automatic check_extremes();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    push_sample(16'sd0);
    push_sample(16'sd32767);
    push_sample(-16'sd32768);
    push_sample(16'sd32767);
    push_sample(-16'sd1);
    push_sample(16'sd1);
    push_sample(16'sd0);
    push_sample(16'sh5555);
    push_sample(16'shAAAA);
    push_sample(16'sd0);
    release_samples();
  endtask

  // Small reversals leave the low operators clamped and the high ones free,
  // which is where the memory of the model shows; a repeated sample gives
  // a zero step.
  task automatic check_reversals();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    push_sample(16'sd1000);
    push_sample(16'sd400);
    push_sample(16'sd1200);
    push_sample(-16'sd500);
    push_sample(-16'sd480);
    push_sample(-16'sd480);
    push_sample(16'sd2500);
    release_samples();
  endtask

  // Hold the result side off for several walks while samples keep coming:
  // one result parks in the output register, the next in the MAC result
  // register, and then the sample input must stall.
  task automatic check_backpressure();
    await_drain();
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    hold_left = 4 * (NUM_OPS + 8);
    push_sample(16'sd3000);
    push_sample(-16'sd7000);
    push_sample(16'sd150);
    push_sample(16'sd9000);
    release_samples();
    await_drain();
  endtask

  // Mostly a random walk with bounded steps, so operators are partly
  // clamped and partly free, mixed with arbitrary samples and full-scale
  // jumps. Gaps on both sides switch on and off in runs.
  task automatic check_random_walk();
    int                         pos;
    int                         kind;
    logic signed [SAMPLE_W-1:0] value;
    pos     = last_sample;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        tx_idle = !tx_idle;
      end
      if ($urandom_range(0, 19) == 0) begin
        rx_idle = !rx_idle;
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        pos = pos + $urandom_range(0, 6000) - 3000;
        if (pos > 32767) begin
          pos = 32767;
        end
        if (pos < -32768) begin
          pos = -32768;
        end
        value = SAMPLE_W'(pos);
      end else if (kind < 85) begin
        value = SAMPLE_W'($urandom_range(0, 65535));
      end else begin
        value = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
      end
      pos = int'(value);
      push_sample(value);
    end
    release_samples();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin : main_sequence
    rst            = 1'b1;
    samples.valid  = 1'b0;
    samples.sample = '0;
    fail_count     = 0;
    tx_idle        = 1'b0;
    rx_idle        = 1'b0;
    hold_left      = 0;
    out_stall_left = 0;
    last_sample    = 0;
    for (int i = 0; i < NUM_OPS; i++) begin
      op_weight[i] = gauss_weight(i);
      op_state[i]  = 0;
    end

    // hold reset while the clock runs, then drop it between edges
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_extremes();
    check_reversals();
    check_backpressure();
    check_random_walk();

    await_drain();
    if (pending_outputs.size() != 0) begin
      $error("hysteresis_out: %0d expected results never arrived", pending_outputs.size());
      fail_count++;
    end
    // Allow one more walk so that a stray result has time to show.
    repeat (NUM_OPS + 16) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_CYCLES * 2 * HALF_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
